// ----- rtl/sfdf_pkg.sv -----
// ----------------------------------------------------------------------------
// sfdf_pkg
// Shared constants and types for the signed fixed-point decimal formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package sfdf_pkg;

  // Default number of decimal digit cells.
  localparam int MaxDigitsDefault = 10;

  // Magnitude width and the number of magnitude bits fed into the cells per cycle.
  localparam int MagW        = 32;
  localparam int BitsPerStep = 4;
  localparam int Steps       = MagW / BitsPerStep;
  localparam int StepW       = $clog2(Steps);

  // ASCII codes.
  localparam logic [6:0] ChSpace = 7'h20;
  localparam logic [6:0] ChMinus = 7'h2D;
  localparam logic [6:0] ChPoint = 7'h2E;
  localparam logic [6:0] ChZero  = 7'h30;

  // Per-number side information handed from the converter to the emitter.
  typedef struct packed {
    logic       neg;
    logic [3:0] point;
  } num_info_t;

endpackage

`default_nettype wire

// ----- rtl/signed_fixed_decimal_formatter_unit.sv -----
// ----------------------------------------------------------------------------
// signed_fixed_decimal_formatter_unit
// Prints a signed 32-bit number as a sign character followed by its low
// decimal digits, with an optional decimal point, as a stream of ASCII items.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   value_i, digit_count_i,
//                                                 point_position_i
//   out      output     out_valid_o / out_stall_i character_o, last_o
//
// The converter loads an accepted item and then shifts its magnitude, four bits
// per step, through the row of digit cells. It then sends 1 + count (+1 when
// the point falls within the digits) characters, one per cycle while out is not
// stalled. The converter works on the next item while the emitter sends the
// current one. Reset is asynchronous and active low; out stalls simply hold the
// output register and, once the converter has finished, back up into in_stall_o.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_fixed_decimal_formatter_unit
  import sfdf_pkg::*;
#(
  parameter int MAX_DIGITS = MaxDigitsDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic signed [MagW-1:0] value_i,
  input  wire logic        [3:0]      digit_count_i,
  input  wire logic        [3:0]      point_position_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic             [6:0]      character_o,
  output logic                        last_o
);

  localparam int IW = $clog2(MAX_DIGITS + 1);

  logic                       res_valid, res_take;
  num_info_t                  res_info;
  logic [IW-1:0]              res_count;
  logic [MAX_DIGITS-1:0][3:0] res_digits;

  sfdf_conv #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_conv (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .value_i          (value_i),
    .digit_count_i    (digit_count_i),
    .point_position_i (point_position_i),
    .res_valid_o      (res_valid),
    .res_take_i       (res_take),
    .res_info_o       (res_info),
    .res_count_o      (res_count),
    .res_digits_o     (res_digits)
  );

  sfdf_emit #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_take_o   (res_take),
    .res_info_i   (res_info),
    .res_count_i  (res_count),
    .res_digits_i (res_digits),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .character_o  (character_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ----- rtl/sfdf_cell.sv -----
// ----------------------------------------------------------------------------
// sfdf_cell
// One BCD digit cell of the shift-and-add-3 chain.
// ----------------------------------------------------------------------------
`default_nettype none

module sfdf_cell
  import sfdf_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   clear_i,
  input  wire logic                   shift_i,
  input  wire logic [BitsPerStep-1:0] bit_i,
  output logic      [BitsPerStep-1:0] carry_o,
  output logic      [3:0]             digit_o
);

  logic [3:0] digit_q, digit_d;

  // Each step corrects the digit, then shifts one bit in from the neighbor below.
  // The bit leaving the top of the digit goes to the neighbor above.
  always_comb begin
    logic [3:0] d;
    logic [3:0] c;
    d       = digit_q;
    c       = '0;
    carry_o = '0;
    for (int j = 0; j < BitsPerStep; j++) begin
      c          = (d >= 4'd5) ? d + 4'd3 : d;
      carry_o[j] = c[3];
      d          = {c[2:0], bit_i[j]};
    end
    digit_d = d;
  end

  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      digit_q <= '0;
    end else if (shift_i) begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule

`default_nettype wire

// ----- rtl/sfdf_conv.sv -----
// ----------------------------------------------------------------------------
// sfdf_conv
// Takes the magnitude of the input value and turns it into BCD digits in a
// row of digit cells, four bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfdf_conv
  import sfdf_pkg::*;
#(
  parameter int MAX_DIGITS = MaxDigitsDefault,
  localparam int IW        = $clog2(MAX_DIGITS + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [MagW-1:0]         value_i,
  input  wire logic        [3:0]              digit_count_i,
  input  wire logic        [3:0]              point_position_i,
  output logic                                res_valid_o,
  input  wire logic                           res_take_i,
  output num_info_t                           res_info_o,
  output logic             [IW-1:0]           res_count_o,
  output logic             [MAX_DIGITS-1:0][3:0] res_digits_o
);

  localparam int CmpW = (IW > 4) ? IW : 4;

  logic                   busy_q, done_q;
  logic [StepW-1:0]       step_q;
  logic [MagW-1:0]        mag_q;
  logic [MagW-1:0]        raw;
  num_info_t              info_q;
  logic [IW-1:0]          cnt_q;
  logic                   accept;
  logic [BitsPerStep-1:0] feed;
  logic [BitsPerStep-1:0] carry [MAX_DIGITS];

  assign in_stall_o = busy_q || (done_q && !res_take_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign raw        = value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      if (res_take_i) begin
        done_q <= 1'b0;
      end
      if (accept) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_q  <= raw[MagW-1] ? (~raw + 1'b1) : raw;
      info_q <= '{neg: raw[MagW-1], point: point_position_i};
      if (CmpW'(digit_count_i) > CmpW'(MAX_DIGITS)) begin
        cnt_q <= IW'(MAX_DIGITS);
      end else begin
        cnt_q <= IW'(digit_count_i);
      end
    end else if (busy_q) begin
      mag_q <= mag_q << BitsPerStep;
    end
  end

  // The magnitude enters the lowest cell most significant bit first.
  always_comb begin
    for (int j = 0; j < BitsPerStep; j++) begin
      feed[j] = mag_q[MagW-1-j];
    end
  end

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    sfdf_cell u_cell (
      .clk_i   (clk_i),
      .clear_i (accept),
      .shift_i (busy_q),
      .bit_i   ((i == 0) ? feed : carry[(i == 0) ? 0 : i - 1]),
      .carry_o (carry[i]),
      .digit_o (res_digits_o[i])
    );
  end

  assign res_valid_o = done_q;
  assign res_info_o  = info_q;
  assign res_count_o = cnt_q;

endmodule

`default_nettype wire

// ----- rtl/sfdf_emit.sv -----
// ----------------------------------------------------------------------------
// sfdf_emit
// Walks one converted number and sends its characters, one item per cycle while
// out is not stalled, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfdf_emit
  import sfdf_pkg::*;
#(
  parameter int MAX_DIGITS = MaxDigitsDefault,
  localparam int IW        = $clog2(MAX_DIGITS + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        res_valid_i,
  output logic                             res_take_o,
  input  wire num_info_t                   res_info_i,
  input  wire logic [IW-1:0]               res_count_i,
  input  wire logic [MAX_DIGITS-1:0][3:0]  res_digits_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [6:0]                  character_o,
  output logic                             last_o
);

  localparam int CmpW  = (IW > 4) ? IW : 4;
  localparam int DigIW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic                       active_q, sign_q, dot_q, out_valid_q;
  logic [IW-1:0]              idx_q;
  num_info_t                  info_q;
  logic [IW-1:0]              cnt_q;
  logic [MAX_DIGITS-1:0][3:0] digits_q;
  logic [6:0]                 char_q;
  logic                       last_q;
  logic                       adv, dot_now, fin;
  logic [6:0]                 gen_char;
  logic                       gen_last;
  logic [3:0]                 cur_digit;

  assign adv       = !out_valid_q || !out_stall_i;
  assign dot_now   = !sign_q && !dot_q && (CmpW'(idx_q) == CmpW'(info_q.point));
  assign cur_digit = digits_q[DigIW'(idx_q - 1'b1)];

  always_comb begin
    if (sign_q) begin
      gen_char = info_q.neg ? ChMinus : ChSpace;
      gen_last = (cnt_q == '0);
    end else if (dot_now) begin
      gen_char = ChPoint;
      gen_last = 1'b0;
    end else begin
      gen_char = ChZero + 7'(cur_digit);
      gen_last = (idx_q == IW'(1));
    end
  end

  // The next number is loaded in the cycle that moves the final character into the output register, or when idle.
  assign fin        = active_q && adv && gen_last;
  assign res_take_o = res_valid_i && (!active_q || fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      sign_q      <= 1'b0;
      dot_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= active_q;
      end
      if (active_q && adv) begin
        if (sign_q) begin
          idx_q <= cnt_q;
          dot_q <= 1'b0;
        end else if (dot_now) begin
          dot_q <= 1'b1;
        end else begin
          idx_q <= idx_q - 1'b1;
          dot_q <= 1'b0;
        end
      end
      if (res_take_o) begin
        active_q <= 1'b1;
        sign_q   <= 1'b1;
      end else if (fin) begin
        active_q <= 1'b0;
      end else if (active_q && adv) begin
        sign_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take_o) begin
      info_q   <= res_info_i;
      cnt_q    <= res_count_i;
      digits_q <= res_digits_i;
    end
    if (active_q && adv) begin
      char_q <= gen_char;
      last_q <= gen_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ----- rtl/sfdf_checker.sv -----
// ----------------------------------------------------------------------------
// sfdf_checker
// Port-level checks on the character stream of the formatter.
// ----------------------------------------------------------------------------
`default_nettype none

module sfdf_checker
  import sfdf_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [6:0]  character_o,
  input wire logic        last_o
);

  // High when the next output item must start a new number.
  logic expect_sign_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_sign_q <= 1'b1;
    end else if (out_valid_o && !out_stall_i) begin
      expect_sign_q <= last_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(character_o) && $stable(last_o))
    else $error("stalled output item changed");

  a_sign_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && expect_sign_q |-> character_o == ChSpace || character_o == ChMinus)
    else $error("number does not start with a sign character");

  a_body_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !expect_sign_q |->
      character_o == ChPoint || (character_o >= ChZero && character_o <= ChZero + 7'd9))
    else $error("illegal character inside a number");

  a_point_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && character_o == ChPoint |-> !last_o)
    else $error("number ends with a point");

endmodule

bind signed_fixed_decimal_formatter_unit sfdf_checker u_sfdf_checker (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the signed fixed-point decimal formatter on its two streaming
// channels. A queue of numbers feeds a clocked driver, and a clocked monitor
// compares every character leaving the block, field by field, against a
// running list of characters predicted for each accepted number. Directed
// corner cases come first, then random numbers under three idling mixes.
// ----------------------------------------------------------------------------

module testbench
  import sfdf_pkg::*;
();

  localparam int MaxDigits  = MaxDigitsDefault;
  localparam int ClkPeriod  = 10;
  localparam int CycleLimit = 400000;
  localparam int RandomNumbersPerPhase = 134;

  typedef struct {
    logic signed [MagW-1:0] value;
    logic [3:0]             count;
    logic [3:0]             point;
  } number_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } text_char_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic signed [MagW-1:0] value_i;
  logic [3:0]             digit_count_i;
  logic [3:0]             point_position_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [6:0]             character_o;
  logic                   last_o;

  number_t    pending_numbers[$];
  text_char_t expected_chars[$];
  number_t    next_number;
  text_char_t seen_char;
  text_char_t wanted_char;
  bit         number_taken;
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  signed_fixed_decimal_formatter_unit #(
    .MAX_DIGITS(MaxDigits)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .value_i         (value_i),
    .digit_count_i   (digit_count_i),
    .point_position_i(point_position_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .character_o     (character_o),
    .last_o          (last_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Appends the characters that one number turns into.
  task automatic predict_text(input logic signed [MagW-1:0] value, input logic [3:0] count,
                              input logic [3:0] point);
    logic [MagW-1:0] raw;
    logic [MagW-1:0] mag;
    logic [3:0]      digit_at[MaxDigits];
    int              shown;
    raw   = value;
    mag   = raw[MagW-1] ? (~raw + 32'd1) : raw;
    shown = (count > MaxDigits) ? MaxDigits : int'(count);
    for (int i = 0; i < MaxDigits; i++) begin
      digit_at[i] = 4'(mag % 10);
      mag         = mag / 10;
    end
    expected_chars.push_back('{ch: raw[MagW-1] ? ChMinus : ChSpace, last: (shown == 0)});
    for (int i = shown; i >= 1; i--) begin
      if (i == int'(point)) begin
        expected_chars.push_back('{ch: ChPoint, last: 1'b0});
      end
      expected_chars.push_back('{ch: ChZero + 7'(digit_at[i-1]), last: (i == 1)});
    end
  endtask

  task automatic add_number(input logic signed [MagW-1:0] value, input logic [3:0] count,
                            input logic [3:0] point);
    pending_numbers.push_back('{value: value, count: count, point: point});
  endtask

  task automatic add_random_number();
    logic signed [MagW-1:0] value;
    logic [3:0]             count;
    logic [3:0]             point;
    int                     shown;
    case ($urandom_range(0, 9))
      0, 1, 2: value = $urandom;
      3: begin
        case ($urandom_range(0, 4))
          0: value = 32'sh8000_0000;
          1: value = 32'sh7FFF_FFFF;
          2: value = 0;
          3: value = -1;
          default: value = 32'sh8000_0000 + $urandom_range(1, 9);
        endcase
      end
      4, 5: value = $urandom_range(0, 999);
      default: value = $urandom_range(0, 99999999);
    endcase
    if ($urandom_range(0, 2) == 0) begin
      value = -value;
    end
    // Counts above the digit limit are rarer than normal counts.
    count = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(11, 15))
                                        : 4'($urandom_range(0, MaxDigits));
    shown = (count > MaxDigits) ? MaxDigits : int'(count);
    point = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                        : 4'($urandom_range(0, shown + 1));
    add_number(value, count, point);
  endtask

  // Holds the sender back until every queued number is in and every
  // predicted character has come out.
  task automatic wait_until_drained();
    while (pending_numbers.size() != 0 || in_valid_i || expected_chars.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Driver: a new number goes out at the falling edge once the previous one
  // has been accepted; a stalled number is held unchanged.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !number_taken) begin
        // Keep presenting the same number.
      end else if (pending_numbers.size() != 0 &&
                   $urandom_range(0, 99) >= sender_idle_pct) begin
        next_number = pending_numbers.pop_front();
        in_valid_i       <= 1'b1;
        value_i          <= next_number.value;
        digit_count_i    <= next_number.count;
        point_position_i <= next_number.point;
      end else begin
        in_valid_i <= 1'b0;
      end
      out_stall_i <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  // Monitor: predicts on input acceptance and checks every accepted character.
  always @(posedge clk_i) begin
    number_taken = in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (number_taken) begin
        predict_text(value_i, digit_count_i, point_position_i);
      end
      if (out_valid_o && !out_stall_i) begin
        seen_char = '{ch: character_o, last: last_o};
        if (expected_chars.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected character %h last %b", seen_char.ch, seen_char.last);
          end
        end else begin
          wanted_char = expected_chars.pop_front();
          if (seen_char.ch !== wanted_char.ch || seen_char.last !== wanted_char.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("character mismatch: expected %h last %b, got %h last %b",
                       wanted_char.ch, wanted_char.last, seen_char.ch, seen_char.last);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    value_i           = '0;
    digit_count_i     = '0;
    point_position_i  = '0;
    out_stall_i       = 1'b0;
    sender_idle_pct   = 36;
    receiver_idle_pct = 46;
    mismatch_count    = 0;
    cycle_count       = 0;
    number_taken      = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Corner cases: no digits, points at both ends and past the digits,
    // saturated counts, dropped high digits and the most negative value.
    @(posedge clk_i);
    add_number(0, 0, 0);
    add_number(-5, 0, 3);
    add_number(0, 1, 1);
    add_number(7, 1, 0);
    add_number(12345, 5, 0);
    add_number(12345, 5, 3);
    add_number(-12345, 5, 5);
    add_number(12345, 5, 6);
    add_number(32'sh7FFF_FFFF, 10, 0);
    add_number(32'sh8000_0000, 10, 10);
    add_number(32'sh8000_0000, 15, 4);
    add_number(-1, 10, 1);
    add_number(987654321, 3, 2);
    add_number(-1000000000, 15, 15);
    add_number(1, 11, 11);
    add_number(1234567890, 12, 2);
    add_number(-7, 4, 15);
    add_number(99, 2, 1);
    add_number(-2147483647, 10, 9);
    add_number(0, 10, 10);
    wait_until_drained();

    @(posedge clk_i);
    repeat (RandomNumbersPerPhase) add_random_number();
    wait_until_drained();

    sender_idle_pct   = 46;
    receiver_idle_pct = 36;
    @(posedge clk_i);
    repeat (RandomNumbersPerPhase) add_random_number();
    wait_until_drained();

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    @(posedge clk_i);
    repeat (RandomNumbersPerPhase) add_random_number();
    wait_until_drained();

    // Room for any stray character the block might still send.
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
